/* rtl/core/bvs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bus video sync package
// Shared types, constants and codes of the bus, video and sync logic.
// ----------------------------------------------------------------------------
package bvs_pkg;

	localparam int RAM_BYTES_DEF  = 65536;
	localparam int ROM_BYTES_DEF  = 8192;
	localparam int LINE_HALF_DEF  = 414;

	localparam logic [15:0] CHAR_PAGE_MASK = 16'hfe00;
	localparam logic [7:0]  CHAR_IDX_MASK  = 8'h3f;

	typedef enum logic [3:0] {
		ACT_TICK    = 4'd0,
		ACT_READ    = 4'd1,
		ACT_OPCODE  = 4'd2,
		ACT_WRITE   = 4'd3,
		ACT_PORT_IN = 4'd4,
		ACT_PORT_OUT= 4'd5,
		ACT_INT_ACK = 4'd6,
		ACT_REFRESH = 4'd7,
		ACT_KEY     = 4'd8,
		ACT_ROM_LD  = 4'd9
	} action_t;

	localparam logic [2:0] CFG_LATER     = 3'd0;
	localparam logic [2:0] CFG_RAM_START = 3'd1;
	localparam logic [2:0] CFG_RAM_MASK  = 3'd2;
	localparam logic [2:0] CFG_ROM_MASK  = 3'd3;
	localparam logic [2:0] CFG_HS_BEGIN  = 3'd4;
	localparam logic [2:0] CFG_HS_FINISH = 3'd5;

	typedef struct packed {
		logic        later_model;
		logic [15:0] ram_start;
		logic [15:0] ram_mask;
		logic [12:0] rom_mask;
		logic [8:0]  hs_begin;
		logic [8:0]  hs_finish;
	} cfg_t;

	typedef struct packed {
		logic [3:0]  action;
		logic [15:0] address;
		logic [7:0]  write_data;
		logic [5:0]  cycle_length;
		logic        halt_active;
		logic        tape_level;
		logic [10:0] key_code;
		logic        key_down;
	} in_item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       sync_level;
		logic       nmi_level;
		logic       wait_level;
		logic       irq_pulse;
		logic       pixel_valid;
		logic [7:0] pixel_byte;
	} out_item_t;

	// Memory read and write request presented by the core.
	typedef struct packed {
		logic        ram_rd;
		logic [15:0] ram_addr;
		logic        rom_rd;
		logic [12:0] rom_addr;
		logic        ram_wr;
		logic [7:0]  wdata;
		logic        rom_wr;
	} mem_req_t;

endpackage

/* rtl/core/bvs_stream_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bus video sync stream interface
// Valid/ready channel carrying one payload of a given type.
// ----------------------------------------------------------------------------
interface bvs_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/bvs_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bus video sync memories
// RAM and ROM arrays with one write and one registered read each.
// ----------------------------------------------------------------------------
module bvs_mem #(
	parameter int RAM_BYTES = 65536,
	parameter int ROM_BYTES = 8192
) (
	input  logic              clk,
	input  bvs_pkg::mem_req_t req,
	input  logic              en,
	output logic [7:0]        ram_q,
	output logic [7:0]        rom_q
);
	import bvs_pkg::*;

	localparam int RAW = $clog2(RAM_BYTES);
	localparam int ROW = $clog2(ROM_BYTES);

	logic [7:0] ram_mem [RAM_BYTES];
	logic [7:0] rom_mem [ROM_BYTES];
	logic [RAW-1:0] ram_idx;
	logic [ROW-1:0] rom_idx;

	assign ram_idx = req.ram_addr[RAW-1:0];
	assign rom_idx = req.rom_addr[ROW-1:0];

	always_ff @(posedge clk) begin
		if (en && req.ram_wr) begin
			ram_mem[ram_idx] <= req.wdata;
		end
		if (en && req.ram_rd) begin
			ram_q <= ram_mem[ram_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (en && req.rom_wr) begin
			rom_mem[rom_idx] <= req.wdata;
		end
		if (en && req.rom_rd) begin
			rom_q <= rom_mem[rom_idx];
		end
	end
endmodule

/* rtl/core/bus_video_sync_logic_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bus video sync logic core
// Timing, sync, keyboard and memory access of a processor-driven display.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  in_ch    in   action, address, write_data, cycle_length, halt, tape, key
//  out_ch   out  read_data, sync, nmi, wait, irq, pixel_valid, pixel_byte
//  cfg      in   cfg_we, cfg_index, cfg_data
// One transaction per cycle while the output is not stalled. Stage 1 updates
// timing and issues memory reads and writes, stage 2 takes the registered read
// data and the character fetch uses the prior opcode-cycle latch, so a refresh
// right after its opcode fetch reads the latch from a bypass. The result passes
// through the stage 2 and output registers. Reset clears control state;
// memories are not cleared. A stalled output holds both stages.
module bus_video_sync_logic_core #(
	parameter int RAM_BYTES = bvs_pkg::RAM_BYTES_DEF,
	parameter int ROM_BYTES = bvs_pkg::ROM_BYTES_DEF,
	parameter int LINE_HALF_CYCLES = bvs_pkg::LINE_HALF_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	bvs_stream_if.sink   in_ch,
	bvs_stream_if.source out_ch
);
	import bvs_pkg::*;

	localparam int CW = $clog2(LINE_HALF_CYCLES + 64) + 1;
	localparam int SAT_MOD = 65535 % LINE_HALF_CYCLES;

	cfg_t cfg_q;
	logic [15:0] hcount_q;
	logic [CW-1:0] hmod_q;
	logic [2:0]  char_line_q;
	logic nmi_en_q, vsync_q, hsync_q, nmi_q, wait_q;
	logic [7:0] key_rows_q [8];

	// Stage 2 registers.
	logic        v_s2;
	logic [3:0]  act_s2;
	logic        rd_ram_s2, latch_s2, refr_s2, fetch_rom_s2;
	logic [7:0]  rd_fix_s2, inv_s2;
	out_item_t   base_s2;

	// Display latch: value captured in stage 2 from RAM data, or from the pixel byte on a refresh.
	logic [7:0] latch_q;
	logic       latch_full_q;

	out_item_t out_q;
	logic      out_v_q;

	logic [7:0] ram_q, rom_q;
	mem_req_t   req;
	logic       adv;
	in_item_t   it;

	assign it = in_ch.data;
	assign adv = !out_v_q || out_ch.ready;
	assign in_ch.ready = adv;

	// Latch view seen by stage 1, with forwarding from stage 2.
	logic       s2_latches;
	logic [7:0] latch_eff;
	logic       latch_full_eff;
	assign s2_latches = v_s2 && latch_s2 && !ram_q[6];
	always_comb begin
		latch_eff = latch_q;
		latch_full_eff = latch_full_q;
		if (s2_latches) begin
			latch_eff = ram_q;
			latch_full_eff = 1'b1;
		end
		if (v_s2 && refr_s2) begin
			latch_full_eff = 1'b0;
		end
	end

	// Timing update. The line position modulo the line length is kept beside
	// the counter so that the later model can wrap from any count.
	logic [16:0] now;
	logic [CW-1:0] hsum, hwrap, hmod_n;
	logic        beg_x, fin_x;
	logic        hs_n, nmi_n, wait_n, vs_n, nen_n;
	logic [2:0]  cl_n;
	logic [15:0] hc_n;
	logic        is_bus;
	logic [7:0]  port_v;
	logic [15:0] ca;
	logic        ram_sel;

	always_comb begin
		is_bus = !(it.action == ACT_KEY || it.action == ACT_ROM_LD);
		now = {1'b0, hcount_q} + 17'(it.cycle_length);
		hsum = hmod_q + CW'(it.cycle_length);
		hwrap = (hsum >= CW'(LINE_HALF_CYCLES)) ? hsum - CW'(LINE_HALF_CYCLES) : hsum;
		beg_x = (17'(hcount_q) < 17'(cfg_q.hs_begin)) && (now >= 17'(cfg_q.hs_begin));
		fin_x = (17'(hcount_q) < 17'(cfg_q.hs_finish)) && (now >= 17'(cfg_q.hs_finish));
		hs_n = hsync_q; nmi_n = nmi_q; wait_n = wait_q; cl_n = char_line_q;
		vs_n = vsync_q; nen_n = nmi_en_q; hc_n = hcount_q; hmod_n = hmod_q;
		port_v = 8'hff;
		if (is_bus) begin
			if (beg_x) begin
				hs_n = 1'b1;
				cl_n = char_line_q + 3'd1;
				if (nmi_en_q) nmi_n = 1'b1;
			end else if (fin_x) begin
				hs_n = 1'b0;
				if (nmi_en_q) begin
					nmi_n = 1'b0;
					wait_n = 1'b0;
				end
			end
			if (cfg_q.later_model) begin
				hmod_n = hwrap;
				hc_n = 16'(hwrap);
			end else begin
				hc_n = now[16] ? 16'hffff : now[15:0];
				hmod_n = now[16] ? CW'(SAT_MOD) : hwrap;
			end
			if (nmi_en_q && !it.halt_active && nmi_n) wait_n = 1'b1;
			case (it.action)
				ACT_PORT_IN: begin
					if (!it.address[0]) begin
						if (!nmi_en_q) vs_n = 1'b1;
						for (int c = 0; c < 8; c++) begin
							if (!it.address[8+c]) port_v = port_v & key_rows_q[c];
						end
						if (!it.tape_level) port_v = port_v & 8'h7f;
					end
				end
				ACT_PORT_OUT: begin
					if (!nmi_en_q) begin
						cl_n = 3'd0;
						vs_n = 1'b0;
					end
					if (!it.address[1]) nen_n = 1'b0;
					if (!it.address[0]) nen_n = cfg_q.later_model;
				end
				ACT_INT_ACK: begin
					hc_n = 16'd2;
					hmod_n = CW'(2);
				end
				default: ;
			endcase
		end
	end

	assign ca = (it.address & CHAR_PAGE_MASK) |
		{5'd0, (latch_eff & CHAR_IDX_MASK), 3'd0} | {13'd0, cl_n};
	assign ram_sel = it.address >= cfg_q.ram_start;

	always_comb begin
		req = '0;
		req.wdata = it.write_data;
		unique case (it.action)
			ACT_READ, ACT_OPCODE: begin
				req.ram_rd = ram_sel;
				req.rom_rd = !ram_sel;
			end
			ACT_WRITE:   req.ram_wr = ram_sel;
			ACT_ROM_LD:  req.rom_wr = 1'b1;
			ACT_REFRESH: begin
				req.rom_rd = ca < cfg_q.ram_start;
				req.ram_rd = !(ca < cfg_q.ram_start);
			end
			default: ;
		endcase
		req.ram_addr = it.address & cfg_q.ram_mask;
		req.rom_addr = (it.action == ACT_ROM_LD) ? it.address[12:0] :
			((it.action == ACT_REFRESH) ? ca[12:0] : it.address[12:0]) & cfg_q.rom_mask;
		req.ram_rd = req.ram_rd && in_ch.valid;
		req.rom_rd = req.rom_rd && in_ch.valid;
		req.ram_wr = req.ram_wr && in_ch.valid;
		req.rom_wr = req.rom_wr && in_ch.valid;
	end

	bvs_mem #(.RAM_BYTES(RAM_BYTES), .ROM_BYTES(ROM_BYTES)) u_mem (
		.clk(clk), .req(req), .en(adv), .ram_q(ram_q), .rom_q(rom_q)
	);

	logic acc;
	assign acc = in_ch.valid && adv;

	logic [7:0] pix_s2;
	logic [7:0] latch_n;
	logic       latch_full_n;
	out_item_t  out_n;

	assign pix_s2 = (fetch_rom_s2 ? rom_q : ram_q) ^ inv_s2;

	always_comb begin
		latch_n = latch_eff;
		if (v_s2 && refr_s2 && !s2_latches) latch_n = pix_s2;
		latch_full_n = latch_full_eff;
		if (acc && it.action == ACT_REFRESH) latch_full_n = 1'b0;
	end

	always_comb begin
		out_n = base_s2;
		if (act_s2 == ACT_READ || act_s2 == ACT_OPCODE) begin
			out_n.read_data = rd_ram_s2 ? (latch_s2 && !ram_q[6] ? 8'h00 : ram_q) : rom_q;
		end else begin
			out_n.read_data = rd_fix_s2;
		end
		if (refr_s2) begin
			out_n.pixel_valid = 1'b1;
			out_n.pixel_byte = pix_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{later_model: 1'b1, ram_start: 16'd16384, ram_mask: 16'd1023,
				rom_mask: 13'd8191, hs_begin: 9'd32, hs_finish: 9'd64};
			hcount_q <= '0; hmod_q <= '0; char_line_q <= '0;
			nmi_en_q <= 1'b0; vsync_q <= 1'b0; hsync_q <= 1'b0;
			nmi_q <= 1'b0; wait_q <= 1'b0;
			latch_q <= '0; latch_full_q <= 1'b0;
			for (int r = 0; r < 8; r++) key_rows_q[r] <= 8'hff;
			v_s2 <= 1'b0; out_v_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_LATER:     cfg_q.later_model <= cfg_data[0];
					CFG_RAM_START: cfg_q.ram_start <= cfg_data;
					CFG_RAM_MASK:  cfg_q.ram_mask <= cfg_data;
					CFG_ROM_MASK:  cfg_q.rom_mask <= cfg_data[12:0];
					CFG_HS_BEGIN:  cfg_q.hs_begin <= cfg_data[8:0];
					CFG_HS_FINISH: cfg_q.hs_finish <= cfg_data[8:0];
					default: ;
				endcase
			end
			if (adv) begin
				latch_q <= latch_n;
				latch_full_q <= latch_full_n;
				v_s2 <= acc;
				out_v_q <= v_s2;
			end
			if (acc) begin
				hcount_q <= hc_n; hmod_q <= hmod_n; char_line_q <= cl_n; nmi_en_q <= nen_n;
				vsync_q <= vs_n; hsync_q <= hs_n; nmi_q <= nmi_n; wait_q <= wait_n;
				if (it.action == ACT_KEY) begin
					if (it.key_down) begin
						key_rows_q[it.key_code[10:8]] <=
							key_rows_q[it.key_code[10:8]] & ~it.key_code[7:0];
					end else begin
						key_rows_q[it.key_code[10:8]] <=
							key_rows_q[it.key_code[10:8]] | it.key_code[7:0];
					end
				end
			end
		end
	end

	// Stage 2 payload.
	always_ff @(posedge clk) begin
		if (adv) begin
			act_s2 <= it.action;
			rd_ram_s2 <= req.ram_rd && (it.action != ACT_REFRESH);
			latch_s2 <= acc && it.action == ACT_OPCODE && ram_sel &&
				it.address[15] && !it.halt_active;
			refr_s2 <= acc && it.action == ACT_REFRESH && latch_full_eff;
			fetch_rom_s2 <= ca < cfg_q.ram_start;
			inv_s2 <= latch_eff[7] ? 8'h00 : 8'hff;
			rd_fix_s2 <= (it.action == ACT_PORT_IN) ? port_v :
				((it.action == ACT_INT_ACK) ? 8'hff : 8'h00);
			base_s2.read_data <= '0;
			base_s2.sync_level <= vs_n || hs_n;
			base_s2.nmi_level <= nmi_n;
			base_s2.wait_level <= wait_n;
			base_s2.irq_pulse <= it.action == ACT_REFRESH && !it.address[6];
			base_s2.pixel_valid <= 1'b0;
			base_s2.pixel_byte <= '0;
			if (v_s2) begin
				out_q <= out_n;
			end
		end
	end

	assign out_ch.valid = out_v_q;
	assign out_ch.data = out_q;

`ifndef NO_ASSERTIONS
	a_pix_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.data.pixel_valid |-> out_ch.data.pixel_byte == 8'h00)
		else $error("pixel byte without pixel valid");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
		else $error("stalled result changed");
	a_hcount: assert property (@(posedge clk) disable iff (!arst_n)
		acc && is_bus && cfg_q.later_model && !cfg_we |=>
		hcount_q < 16'(LINE_HALF_CYCLES))
		else $error("line counter out of range");
`endif
endmodule
